// ----- rtl/bvg_pkg.sv -----
`default_nettype none

package bvg_pkg;

  localparam int ADC_W     = 12;
  localparam int RATIO_W   = 12;
  localparam int MV_W      = 16;
  localparam int PCT_W     = 8;
  localparam int OPND_W    = 12;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int DIVISOR_W = 12;

  localparam int SAMPLES_PER_BURST_DEF = 16;

  localparam logic [OPND_W-1:0]    PIN_FULL_SCALE_MV = 12'd3100;
  localparam logic [RATIO_W-1:0]   RATIO_DEFAULT_Q8  = 12'd512;
  localparam logic [RATIO_W-1:0]   RATIO_MIN_Q8      = 12'd26;

  localparam logic [PCT_W-1:0] PCT_NONE = 8'hFF;
  localparam logic [PCT_W-1:0] PCT_FULL = 8'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 8'd0;

  localparam int CURVE_POINTS = 11;

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3700,
    16'd3600, 16'd3500, 16'd3400, 16'd3300, 16'd3000
  };

  localparam logic [6:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd35, 7'd20, 7'd10, 7'd5, 7'd0
  };

  // 2^18 / segment span rounded up; exact for the products of at most 1500
  // that one segment gives
  localparam int PCT_RECIP_SHIFT = 18;

  localparam logic [OPND_W-1:0] CURVE_RECIP [CURVE_POINTS-1] = '{
    12'd2622, 12'd2622, 12'd2622, 12'd2622, 12'd2622,
    12'd2622, 12'd2622, 12'd2622, 12'd2622, 12'd874
  };

endpackage

`default_nettype wire

// ----- rtl/battery_voltage_gauge.sv -----
// Battery voltage gauge. Takes a burst of 12-bit ADC words, each flagged good
// or failed, and on the word marked last returns one result: battery
// millivolts (mean of the good samples scaled to pin millivolts by 3100/4095,
// then by the divider ratio in Q8) and a state-of-charge percent interpolated
// over an 11-point Li-ion curve, or -1 with no_sample set for an empty burst.
// Words that do not end a burst are taken one per cycle. A word ending a
// burst holds the input stalled while an iterative divider (one quotient bit
// a cycle, SUM_W steps) forms the mean and one shared multiplier does the
// scaling; the 1/4095 is an add-and-shift on the product and the percent's
// segment division a reciprocal step on that multiplier. The states run
// divide, pin multiply, 1/4095, ratio multiply, curve select, percent
// multiply and percent divide, then load the output register (a clamped
// percent skips the percent steps, an empty burst goes straight there); the
// next word is taken the cycle after, and the next burst's words while the
// result waits in that register. A further burst end waits until it is free.
`default_nettype none

module battery_voltage_gauge #(
  parameter int SAMPLES_PER_BURST = bvg_pkg::SAMPLES_PER_BURST_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bvg_pkg::ADC_W-1:0]   in_adc_sample,
  input  wire logic                        in_sample_ok,
  input  wire logic                        in_burst_last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bvg_pkg::MV_W-1:0]         out_battery_millivolts,
  output logic signed [bvg_pkg::PCT_W-1:0] out_charge_percent,
  output logic                             out_no_sample,
  input  wire logic                        cfg_write,
  input  wire logic [bvg_pkg::RATIO_W-1:0] cfg_data
);
  import bvg_pkg::*;

  localparam int SUM_W = $clog2(SAMPLES_PER_BURST * 4095 + 1);
  localparam int CNT_W = $clog2(SAMPLES_PER_BURST + 1);
  localparam int DVD_W = SUM_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_MUL_PIN,
    ST_DIV_PIN,
    ST_MUL_RATIO,
    ST_PCT_SEL,
    ST_MUL_PCT,
    ST_DIV_PCT,
    ST_FINISH
  } state_t;

  state_t               state_r;
  logic [SUM_W-1:0]     sum_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [RATIO_W-1:0]   ratio_r;

  logic                 div_start_r;
  logic [DVD_W-1:0]     div_dvd_r;
  logic [DIVISOR_W-1:0] div_dvs_r;
  logic                 div_done;
  logic [DVD_W-1:0]     div_quo;

  logic [MV_W-1:0]      mv_r;
  logic [PCT_W-1:0]     pct_r;
  logic                 none_r;
  logic [OPND_W-1:0]    diff_r;
  logic [OPND_W-1:0]    span_pct_r;
  logic [OPND_W-1:0]    recip_r;
  logic [6:0]           base_pct_r;
  logic [PROD_W-1:0]    prod_r;
  logic [OPND_W-1:0]    pin_r;

  logic                 out_valid_r;
  logic [MV_W-1:0]      out_mv_r;
  logic [PCT_W-1:0]     out_pct_r;
  logic                 out_none_r;

  logic [SUM_W-1:0]     sum_nxt;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [RATIO_W-1:0]   ratio_eff;
  logic [OPND_W-1:0]    mul_a;
  logic [OPND_W-1:0]    mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [PROD_W:0]      pin_acc;

  logic [OPND_W-1:0]    sel_diff;
  logic [OPND_W-1:0]    sel_span_pct;
  logic [OPND_W-1:0]    sel_recip;
  logic [6:0]           sel_base;

  bvg_div #(
    .DVD_W(DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Accumulate a good sample until the burst holds its full count
  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (in_sample_ok && (cnt_r < CNT_W'(SAMPLES_PER_BURST))) begin
      sum_nxt = sum_r + SUM_W'(in_adc_sample);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign ratio_eff = (ratio_r < RATIO_MIN_Q8) ? RATIO_DEFAULT_Q8 : ratio_r;

  // Shared multiplier operands
  always_comb begin
    unique case (state_r)
      ST_MUL_PIN: begin
        mul_a = div_quo[OPND_W-1:0];
        mul_b = PIN_FULL_SCALE_MV;
      end
      ST_MUL_RATIO: begin
        mul_a = pin_r;
        mul_b = ratio_eff;
      end
      ST_MUL_PCT: begin
        mul_a = diff_r;
        mul_b = span_pct_r;
      end
      ST_DIV_PCT: begin
        mul_a = prod_r[OPND_W-1:0];
        mul_b = recip_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // 4095 is 2^12 - 1: x / 4095 = (x + x / 4096 + 1) / 4096 while the quotient
  // stays below 4096
  assign pin_acc = {1'b0, prod_r} + (PROD_W+1)'(prod_r[PROD_W-1:ADC_W]) + (PROD_W+1)'(1);

  // Pick the curve segment holding the voltage; segments do not overlap
  always_comb begin
    sel_diff     = '0;
    sel_span_pct = '0;
    sel_recip    = '0;
    sel_base     = '0;
    for (int i = 0; i < CURVE_POINTS - 1; i++) begin
      if (mv_r <= CURVE_MV[i] && mv_r > CURVE_MV[i+1]) begin
        sel_diff     = OPND_W'(mv_r - CURVE_MV[i+1]);
        sel_recip    = CURVE_RECIP[i];
        sel_span_pct = OPND_W'(CURVE_PCT[i] - CURVE_PCT[i+1]);
        sel_base     = CURVE_PCT[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      ratio_r     <= RATIO_DEFAULT_Q8;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= (state_r == ST_IDLE) && in_valid && in_burst_last &&
                     (cnt_nxt != '0);
      if (cfg_write) begin
        ratio_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_burst_last) begin
              sum_r <= '0;
              cnt_r <= '0;
              if (cnt_nxt == '0) begin
                mv_r    <= '0;
                pct_r   <= PCT_NONE;
                none_r  <= 1'b1;
                state_r <= ST_FINISH;
              end else begin
                none_r    <= 1'b0;
                div_dvd_r <= DVD_W'(sum_nxt);
                div_dvs_r <= DIVISOR_W'(cnt_nxt);
                state_r   <= ST_DIV_MEAN;
              end
            end else begin
              sum_r <= sum_nxt;
              cnt_r <= cnt_nxt;
            end
          end
        end
        ST_DIV_MEAN: begin
          if (div_done) begin
            state_r <= ST_MUL_PIN;
          end
        end
        ST_MUL_PIN: begin
          prod_r  <= mul_p;
          state_r <= ST_DIV_PIN;
        end
        ST_DIV_PIN: begin
          pin_r   <= pin_acc[ADC_W+OPND_W-1:ADC_W];
          state_r <= ST_MUL_RATIO;
        end
        ST_MUL_RATIO: begin
          mv_r    <= mul_p[PROD_W-1:8];
          state_r <= ST_PCT_SEL;
        end
        ST_PCT_SEL: begin
          priority if (mv_r == '0) begin
            pct_r   <= PCT_NONE;
            state_r <= ST_FINISH;
          end else if (mv_r >= CURVE_MV[0]) begin
            pct_r   <= PCT_FULL;
            state_r <= ST_FINISH;
          end else if (mv_r <= CURVE_MV[CURVE_POINTS-1]) begin
            pct_r   <= PCT_EMPTY;
            state_r <= ST_FINISH;
          end else begin
            diff_r     <= sel_diff;
            span_pct_r <= sel_span_pct;
            recip_r    <= sel_recip;
            base_pct_r <= sel_base;
            state_r    <= ST_MUL_PCT;
          end
        end
        ST_MUL_PCT: begin
          prod_r  <= mul_p;
          state_r <= ST_DIV_PCT;
        end
        ST_DIV_PCT: begin
          pct_r   <= PCT_W'(base_pct_r) + PCT_W'(mul_p[PROD_W-1:PCT_RECIP_SHIFT]);
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_mv_r    <= mv_r;
            out_pct_r   <= pct_r;
            out_none_r  <= none_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall               = (state_r != ST_IDLE);
  assign out_valid              = out_valid_r;
  assign out_battery_millivolts = out_mv_r;
  assign out_charge_percent     = out_pct_r;
  assign out_no_sample          = out_none_r;

endmodule

`default_nettype wire

// ----- rtl/bvg_div.sv -----
`default_nettype none

module bvg_div #(
  parameter int DVD_W = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [DVD_W-1:0]              dividend,
  input  wire logic [bvg_pkg::DIVISOR_W-1:0] divisor,
  output logic                               done,
  output logic [DVD_W-1:0]                   quotient
);
  import bvg_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DIVISOR_W-1:0] rem_r;
  logic [DVD_W-1:0]     quo_r;
  logic [STEP_W-1:0]    step_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVISOR_W:0]   rem_sh;
  logic                 fits;
  logic [DIVISOR_W:0]   rem_sub;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    fits    = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        step_r <= STEP_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        quo_r  <= {quo_r[DVD_W-2:0], fits};
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/bvg_checker.sv -----
`default_nettype none

module bvg_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic                        in_burst_last,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [bvg_pkg::MV_W-1:0]    out_battery_millivolts,
  input  wire logic signed [bvg_pkg::PCT_W-1:0] out_charge_percent,
  input  wire logic                        out_no_sample
);
  import bvg_pkg::*;

  // A word that ends a burst starts the computation and blocks the input
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_burst_last) |=> in_stall)
    else $error("input not held after a burst-ending word");

  a_empty_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_sample) |->
      (out_battery_millivolts == '0 && out_charge_percent == PCT_NONE))
    else $error("empty burst result malformed");

  a_zero_volts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_battery_millivolts == '0) |-> (out_charge_percent == PCT_NONE))
    else $error("zero voltage without percent of -1");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_battery_millivolts != '0) |->
      (!out_charge_percent[PCT_W-1] && out_charge_percent <= PCT_FULL))
    else $error("percent out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_battery_millivolts) && $stable(out_charge_percent)))
    else $error("stalled result changed");

endmodule

bind battery_voltage_gauge bvg_checker u_bvg_checker (.*);

`default_nettype wire

// ----- tb/battery_voltage_gauge_tb.sv -----
`default_nettype none

module battery_voltage_gauge_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bvg_pkg::*;

  localparam int BURST_MAX = SAMPLES_PER_BURST_DEF;
  localparam int IDLE_CYCLES = 120;
  localparam int unsigned KNEE_MV [CURVE_POINTS] = '{
    4200, 4100, 4000, 3900, 3800, 3700, 3600, 3500, 3400, 3300, 3000
  };
  localparam int unsigned KNEE_PCT [CURVE_POINTS] = '{
    100, 90, 80, 70, 60, 50, 35, 20, 10, 5, 0
  };

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             none;
  } reading_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ADC_W-1:0]    in_adc_sample;
  logic                in_sample_ok;
  logic                in_burst_last;
  logic                out_valid;
  logic                out_stall;
  logic [MV_W-1:0]     out_battery_millivolts;
  logic signed [PCT_W-1:0] out_charge_percent;
  logic                out_no_sample;
  logic                cfg_write;
  logic [RATIO_W-1:0]  cfg_data;

  // gauge model state
  int unsigned ratio_q8;
  int unsigned acc_sum;
  int unsigned acc_count;
  reading_t    readings_due[$];

  bit gaps_on;
  int stall_left = 0;
  int words_sent;
  int readings_seen = 0;
  int empty_bursts;
  int ratio_writes;
  int mismatches = 0;

  battery_voltage_gauge u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_adc_sample          (in_adc_sample),
    .in_sample_ok           (in_sample_ok),
    .in_burst_last          (in_burst_last),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_battery_millivolts (out_battery_millivolts),
    .out_charge_percent     (out_charge_percent),
    .out_no_sample          (out_no_sample),
    .cfg_write              (cfg_write),
    .cfg_data               (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PCT_W-1:0] charge_of(int unsigned mv);
    int unsigned i;
    if (mv == 0) return PCT_NONE;
    if (mv >= KNEE_MV[0]) return 8'd100;
    if (mv <= KNEE_MV[CURVE_POINTS-1]) return 8'd0;
    for (i = 0; i + 1 < CURVE_POINTS; i++) begin
      if (mv <= KNEE_MV[i] && mv > KNEE_MV[i+1]) begin
        return PCT_W'(KNEE_PCT[i+1] + (mv - KNEE_MV[i+1]) *
                      (KNEE_PCT[i] - KNEE_PCT[i+1]) / (KNEE_MV[i] - KNEE_MV[i+1]));
      end
    end
    return PCT_NONE;
  endfunction

  function automatic int unsigned live_ratio();
    return (ratio_q8 < 26) ? 512 : ratio_q8;
  endfunction

  // fold one accepted word into the running mean; queue a reading on burst end
  task automatic absorb_word(int unsigned sample, bit ok, bit last);
    int unsigned mean;
    int unsigned pin_mv;
    int unsigned mv;
    reading_t    rd;
    if (ok && acc_count < BURST_MAX) begin
      acc_sum += sample;
      acc_count++;
    end
    if (last) begin
      if (acc_count == 0) begin
        rd = '{mv: '0, pct: PCT_NONE, none: 1'b1};
        empty_bursts++;
      end else begin
        mean = acc_sum / acc_count;
        pin_mv = mean * 3100 / 4095;
        mv = (pin_mv * live_ratio()) >> 8;
        rd = '{mv: MV_W'(mv), pct: charge_of(mv), none: 1'b0};
      end
      readings_due.push_back(rd);
      acc_sum = 0;
      acc_count = 0;
    end
  endtask

  task automatic send_word(int unsigned sample, bit ok, bit last);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= ADC_W'(sample);
    in_sample_ok  <= ok;
    in_burst_last <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    absorb_word(sample, ok, last);
  endtask

  // drop valid, let every reading drain, then allow the block to fall idle
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_divider(int unsigned value);
    settle_idle();
    cfg_write <= 1'b1;
    cfg_data  <= RATIO_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    ratio_q8 = value & 12'hFFF;
    ratio_writes++;
  endtask

  // mostly bursts aimed into the charge curve, with some wide noise,
  // empty bursts and overlong bursts mixed in
  task automatic send_random_burst();
    int      len;
    int      kind;
    longint  centre;
    longint  spread;
    longint  s;
    int      i;
    bit      ok;
    kind = $urandom_range(0, 19);
    len = (kind == 0) ? $urandom_range(BURST_MAX + 1, BURST_MAX + 8) :
                        $urandom_range(1, BURST_MAX);
    if ($urandom_range(0, 3) != 0) begin
      centre = longint'($urandom_range(2900, 4300)) * 256 * 4095 /
               (longint'(live_ratio()) * 3100);
    end else begin
      centre = $urandom_range(0, 4095);
    end
    if (centre > 4095) centre = 4095;
    spread = ($urandom_range(0, 5) == 0) ? 4095 : $urandom_range(0, 40);
    for (i = 0; i < len; i++) begin
      s = centre + longint'($urandom_range(0, 2 * spread)) - spread;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      ok = (kind == 1) ? 1'b0 : ($urandom_range(0, 7) != 0);
      send_word(int'(s), ok, i == len - 1);
    end
  endtask

  task automatic run_bursts(int words);
    int stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) send_random_burst();
  endtask

  task automatic test_directed();
    int i;
    send_word(0, 1'b1, 1'b1);     // zero voltage although a sample arrived
    send_word(4095, 1'b1, 1'b1);  // full scale
    send_word(4095, 1'b0, 1'b1);  // empty burst
    send_word(4095, 1'b1, 1'b0);  // good sample, then a failed sample on the closing word
    send_word(0, 1'b0, 1'b1);
    // overlong: the seventeenth good sample must be ignored
    for (i = 0; i < BURST_MAX; i++) send_word(2000, 1'b1, 1'b0);
    send_word(0, 1'b1, 1'b1);
    settle_idle();
  endtask

  task automatic test_ratio_extremes();
    set_divider(0);       // tiny ratio falls back to the default
    run_bursts(200);
    set_divider(25);
    run_bursts(200);
    set_divider(26);
    run_bursts(200);
    set_divider(4095);
    run_bursts(200);
  endtask

  task automatic test_random_ratios();
    int i;
    for (i = 0; i < 4; i++) begin
      set_divider((i == 3) ? $urandom_range(0, 25) : $urandom_range(26, 4095));
      run_bursts(170);
    end
  endtask

  task automatic test_steady_stream();
    set_divider($urandom_range(256, 1024));
    gaps_on = 1'b0;
    run_bursts(300);
    settle_idle();
  endtask

  // result stall: random bursts while gaps are on
  always @(negedge clk) begin
    if (!gaps_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    reading_t exp_rd;
    if (rst_n && out_valid && !out_stall) begin
      readings_seen++;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected reading mv=%0d pct=%0d none=%0b", $time,
                 out_battery_millivolts, out_charge_percent, out_no_sample);
        mismatches++;
      end else begin
        exp_rd = readings_due.pop_front();
        if (out_battery_millivolts !== exp_rd.mv) begin
          $display("%0t: millivolts expected %0d actual %0d", $time,
                   exp_rd.mv, out_battery_millivolts);
          mismatches++;
        end
        if (out_charge_percent !== exp_rd.pct) begin
          $display("%0t: percent expected %0d actual %0d", $time,
                   $signed(exp_rd.pct), out_charge_percent);
          mismatches++;
        end
        if (out_no_sample !== exp_rd.none) begin
          $display("%0t: no_sample expected %0b actual %0b", $time,
                   exp_rd.none, out_no_sample);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_adc_sample = '0;
    in_sample_ok = 1'b0;
    in_burst_last = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    ratio_q8 = 512;
    acc_sum = 0;
    acc_count = 0;
    gaps_on = 1'b1;
    words_sent = 0;
    empty_bursts = 0;
    ratio_writes = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_ratio_extremes();
    test_random_ratios();
    test_steady_stream();

    $display("summary: %0d words sent, %0d readings checked (%0d empty bursts)",
             words_sent, readings_seen, empty_bursts);
    $display("summary: %0d divider writes incl. tiny and full-scale ratios", ratio_writes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
